// ===== rtl/core/rfb_pkg.sv =====
// Shared types and constants for the radio frame builder with CRC-16.
// Used by the top level and by the CRC byte update module.
package rfb_pkg;

   // Field widths fixed by the frame format.
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LEN_W      = 7;
   localparam int unsigned PRE_W      = 6;
   localparam int unsigned POST_W     = 5;
   localparam int unsigned CRC_W      = 16;
   localparam int unsigned CSR_IDX_W  = 2;

   // Default largest payload length.
   localparam int unsigned MAX_PAYLOAD_DEF = 127;

   // Caps on the fill byte counts.
   localparam logic [PRE_W-1:0]  PRE_CAP  = 6'd32;
   localparam logic [POST_W-1:0] POST_CAP = 5'd16;

   // CRC-16/CCITT-FALSE.
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   // Register reset values.
   localparam logic [PRE_W-1:0]  PRE_RESET  = 6'd16;
   localparam logic [POST_W-1:0] POST_RESET = 5'd10;
   localparam logic [BYTE_W-1:0] FILL_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h7E;

   // Item opcodes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTAMBLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC      = 2'd3;

   // One input item.
   typedef struct packed {
      logic              opcode;
      logic [LEN_W-1:0]  frame_len;
      logic [BYTE_W-1:0] payload_byte;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              frame_end;
      logic              bad_item;
   } rsp_type;

endpackage

// ===== rtl/core/rfb_crc_byte.sv =====
// Combinational CRC-16/CCITT-FALSE update over one byte, MSB first.
// Depends on rfb_pkg for the widths and the polynomial.
module rfb_crc_byte (
   input  logic [rfb_pkg::CRC_W-1:0]  crc_i,
   input  logic [rfb_pkg::BYTE_W-1:0] data_i,
   output logic [rfb_pkg::CRC_W-1:0]  crc_o
);

   // Fold the byte into the high half, then shift out eight bits.
   always_comb begin
      logic [rfb_pkg::CRC_W-1:0] acc;
      acc = crc_i ^ {data_i, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (acc[rfb_pkg::CRC_W-1]) begin
            acc = {acc[rfb_pkg::CRC_W-2:0], 1'b0} ^ rfb_pkg::CRC_POLY;
         end else begin
            acc = {acc[rfb_pkg::CRC_W-2:0], 1'b0};
         end
      end
      crc_o = acc;
   end

endmodule

// ===== rtl/core/radio_frame_builder_crc16_unit.sv =====
// Radio frame builder: turns start and payload items into a framed byte stream.
// Depends on rfb_pkg and rfb_crc_byte.
//
// Usage: a start item (opcode 0) carries the payload length and produces the
// preamble fill bytes, the sync byte and the length byte. Each payload item
// (opcode 1) produces its byte; the last counted byte is followed by the CRC
// high byte, the CRC low byte and the postamble fill bytes. A zero-length
// start produces the whole frame. A payload item with no frame open produces
// one result flagged bad_item. run_last marks the last result of each item.
// Channels: req_ (input items), rsp_ (result bytes), csr_ (register writes,
// always ready; write only while the block is idle).
// The first result of an item is valid in the cycle after its transfer.
// Throughput: one result byte per cycle while the receiver is ready. A payload item
// that does not close the frame yields one byte; a start yields preamble+2 bytes
// (plus 2+postamble when the length is zero); a closing payload item yields 3+postamble.
// The rate is set by the single output register, which takes one byte a cycle unless stalled.
// A new item is taken once the output register holds its predecessor's last byte,
// so single-byte items follow back to back.
// Reset: synchronous; restores register defaults and closes any open frame.
// A stalled receiver holds the output register and pauses the sequencer.
module radio_frame_builder_crc16_unit #(
   parameter int unsigned MAX_PAYLOAD = rfb_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rfb_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rfb_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rfb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rfb_pkg::BYTE_W-1:0]    csr_data
);

   localparam logic [rfb_pkg::BYTE_W-1:0] MaxLen = rfb_pkg::BYTE_W'(MAX_PAYLOAD);

   // Kind of the byte to be sent.
   typedef enum logic [3:0] {
      K_NONE, K_PRE, K_SYNC, K_LEN, K_DATA, K_BAD, K_CRCH, K_CRCL, K_POST
   } kind_type;

   // Configuration registers.
   logic [rfb_pkg::PRE_W-1:0]  preamble_ff;
   logic [rfb_pkg::POST_W-1:0] postamble_ff;
   logic [rfb_pkg::BYTE_W-1:0] fill_ff;
   logic [rfb_pkg::BYTE_W-1:0] sync_ff;

   // Frame state.
   logic [rfb_pkg::CRC_W-1:0] crc_ff, crc_in;
   logic [rfb_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic                      open_ff, open_in;

   // Remaining output work of the current item.
   kind_type                   job_kind_ff, job_kind_in;
   logic [rfb_pkg::PRE_W-1:0]  job_cnt_ff, job_cnt_in;
   logic                       job_trail_ff, job_trail_in;
   logic [rfb_pkg::LEN_W-1:0]  job_len_ff, job_len_in;
   logic [rfb_pkg::CRC_W-1:0]  job_crc_ff, job_crc_in;

   // Output register.
   logic             rsp_valid_ff;
   rfb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Working signals.
   logic                       busy, out_adv, emit, accept;
   logic [rfb_pkg::PRE_W-1:0]  pre_cap;
   logic [rfb_pkg::POST_W-1:0] post_cap;
   logic [rfb_pkg::LEN_W-1:0]  len_c;
   logic [rfb_pkg::CRC_W-1:0]  crc_src, crc_new;
   logic [rfb_pkg::BYTE_W-1:0] crc_byte;
   logic                       item_trail;
   kind_type                   cur_kind;
   logic [rfb_pkg::PRE_W-1:0]  cur_cnt;
   logic                       cur_trail;
   logic [rfb_pkg::LEN_W-1:0]  cur_len;
   logic [rfb_pkg::CRC_W-1:0]  cur_crc;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Handshake control: a new item enters only when no earlier item has bytes left.
   assign busy      = (job_kind_ff != K_NONE);
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !busy && out_adv;
   assign accept    = req_valid && req_ready;
   assign emit      = out_adv && (busy || req_valid);

   // Capped counts and the clamped length.
   assign pre_cap  = (preamble_ff > rfb_pkg::PRE_CAP) ? rfb_pkg::PRE_CAP : preamble_ff;
   assign post_cap = (postamble_ff > rfb_pkg::POST_CAP) ? rfb_pkg::POST_CAP : postamble_ff;
   assign len_c    = ({1'b0, req_data.frame_len} > MaxLen) ? MaxLen[rfb_pkg::LEN_W-1:0]
                                                          : req_data.frame_len;

   // One CRC update serves both the seed at start and each payload byte.
   assign crc_src  = (req_data.opcode == rfb_pkg::OP_START) ? rfb_pkg::CRC_INIT : crc_ff;
   assign crc_byte = (req_data.opcode == rfb_pkg::OP_START) ? {1'b0, len_c}
                                                           : req_data.payload_byte;

   rfb_crc_byte u_crc (
      .crc_i  (crc_src),
      .data_i (crc_byte),
      .crc_o  (crc_new)
   );

   // Whether the trailer follows this item.
   assign item_trail = (req_data.opcode == rfb_pkg::OP_START) ? (len_c == '0)
                                                             : (rem_ff == 7'd1);

   // Select the byte to send: the pending job, or else the first byte of the new item.
   always_comb begin
      if (busy) begin
         cur_kind  = job_kind_ff;
         cur_cnt   = job_cnt_ff;
         cur_trail = job_trail_ff;
         cur_len   = job_len_ff;
         cur_crc   = job_crc_ff;
      end else begin
         cur_trail = item_trail;
         cur_len   = len_c;
         cur_crc   = crc_new;
         cur_cnt   = pre_cap;
         if (!req_valid) begin
            cur_kind = K_NONE;
         end else if (req_data.opcode == rfb_pkg::OP_START) begin
            cur_kind = (pre_cap != '0) ? K_PRE : K_SYNC;
         end else if (open_ff) begin
            cur_kind = K_DATA;
         end else begin
            cur_kind = K_BAD;
         end
      end
   end

   // Byte value, flags and the next job step.
   always_comb begin
      job_kind_in  = K_NONE;
      job_cnt_in   = cur_cnt;
      job_trail_in = cur_trail;
      job_len_in   = cur_len;
      job_crc_in   = cur_crc;
      rsp_data_in  = '0;
      unique case (cur_kind)
         K_PRE: begin
            rsp_data_in.out_byte = fill_ff;
            if (cur_cnt > 6'd1) begin
               job_kind_in = K_PRE;
               job_cnt_in  = cur_cnt - 6'd1;
            end else begin
               job_kind_in = K_SYNC;
            end
         end
         K_SYNC: begin
            rsp_data_in.out_byte = sync_ff;
            job_kind_in          = K_LEN;
         end
         K_LEN: begin
            rsp_data_in.out_byte = {1'b0, cur_len};
            job_kind_in          = cur_trail ? K_CRCH : K_NONE;
         end
         K_DATA: begin
            rsp_data_in.out_byte = req_data.payload_byte;
            job_kind_in          = cur_trail ? K_CRCH : K_NONE;
         end
         K_BAD: begin
            rsp_data_in.bad_item = 1'b1;
         end
         K_CRCH: begin
            rsp_data_in.out_byte = cur_crc[15:8];
            job_kind_in          = K_CRCL;
         end
         K_CRCL: begin
            rsp_data_in.out_byte  = cur_crc[7:0];
            rsp_data_in.frame_end = (post_cap == '0);
            if (post_cap != '0) begin
               job_kind_in = K_POST;
               job_cnt_in  = {1'b0, post_cap};
            end
         end
         K_POST: begin
            rsp_data_in.out_byte  = fill_ff;
            rsp_data_in.frame_end = (cur_cnt == 6'd1);
            if (cur_cnt > 6'd1) begin
               job_kind_in = K_POST;
               job_cnt_in  = cur_cnt - 6'd1;
            end
         end
         default: begin
            job_kind_in = K_NONE;
         end
      endcase
      rsp_data_in.run_last = (job_kind_in == K_NONE);
   end

   // Frame state after an accepted item; a closing item restores the CRC seed.
   always_comb begin
      crc_in  = crc_ff;
      rem_in  = rem_ff;
      open_in = open_ff;
      if (req_data.opcode == rfb_pkg::OP_START) begin
         crc_in  = item_trail ? rfb_pkg::CRC_INIT : crc_new;
         rem_in  = len_c;
         open_in = !item_trail;
      end else if (open_ff) begin
         crc_in  = item_trail ? rfb_pkg::CRC_INIT : crc_new;
         rem_in  = rem_ff - 7'd1;
         open_in = !item_trail;
      end
   end

   // Configuration registers take each write transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff  <= rfb_pkg::PRE_RESET;
         postamble_ff <= rfb_pkg::POST_RESET;
         fill_ff      <= rfb_pkg::FILL_RESET;
         sync_ff      <= rfb_pkg::SYNC_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rfb_pkg::CSR_PREAMBLE:  preamble_ff  <= csr_data[rfb_pkg::PRE_W-1:0];
            rfb_pkg::CSR_POSTAMBLE: postamble_ff <= csr_data[rfb_pkg::POST_W-1:0];
            rfb_pkg::CSR_FILL:      fill_ff      <= csr_data;
            rfb_pkg::CSR_SYNC:      sync_ff      <= csr_data;
            default:                preamble_ff  <= preamble_ff;
         endcase
      end
   end

   // Frame state updates on each input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= rfb_pkg::CRC_INIT;
         rem_ff  <= '0;
         open_ff <= 1'b0;
      end else if (accept) begin
         crc_ff  <= crc_in;
         rem_ff  <= rem_in;
         open_ff <= open_in;
      end
   end

   // Sequencer and output register advance together, one byte a cycle unless the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_kind_ff  <= K_NONE;
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         job_kind_ff  <= job_kind_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload of the job and of the result.
   always_ff @(posedge clock) begin
      if (emit) begin
         job_cnt_ff   <= job_cnt_in;
         job_trail_ff <= job_trail_in;
         job_len_ff   <= job_len_in;
         job_crc_ff   <= job_crc_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

endmodule
